[design/ps2_mouse_packet_tracker_defines.svh]
// Assertion macros shared by the checker files of the PS/2 packet tracker.
// Each macro expects i_clk, and PS2MPT_ASSERT also i_rst_n, to be visible where it is used.
`ifndef PS2_MOUSE_PACKET_TRACKER_DEFINES_SVH
`define PS2_MOUSE_PACKET_TRACKER_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted.
`define PS2MPT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked assertion that stays active through reset.
`define PS2MPT_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

[design/ps2mpt_pkg.sv]
// Shared types, constants and helper functions of the PS/2 packet tracker.
// No dependencies; imported by the interfaces, the modules and the checker.
package ps2mpt_pkg;

    localparam int BYTE_W = 8;
    localparam int POS_W  = 12;
    localparam int SIZE_W = 13;
    localparam int DLT_W  = 10;

    // Protocol bytes and header pattern
    localparam logic [BYTE_W-1:0] ACK_BYTE  = 8'hFA;
    localparam logic [BYTE_W-1:0] HDR_MASK  = 8'hC8;
    localparam logic [BYTE_W-1:0] HDR_MATCH = 8'h08;

    // Header bit positions
    localparam int HDR_LEFT  = 0;
    localparam int HDR_RIGHT = 1;
    localparam int HDR_MID   = 2;
    localparam int HDR_XSIGN = 4;
    localparam int HDR_YSIGN = 5;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

    // Clamp limits after reset (size minus one)
    localparam logic [POS_W-1:0] LIM_X_RST = 12'd1023;
    localparam logic [POS_W-1:0] LIM_Y_RST = 12'd767;
    localparam logic [SIZE_W-1:0] SIZE_MAX = 13'd4096;

    typedef logic [1:0] t_btn;
    localparam t_btn BTN_IDLE = 2'd0;
    localparam t_btn BTN_DOWN = 2'd1;
    localparam t_btn BTN_UP   = 2'd2;

    typedef enum logic [3:0] {
        PH_ACK = 4'b0001,
        PH_HDR = 4'b0010,
        PH_XB  = 4'b0100,
        PH_YB  = 4'b1000
    } t_phase;

    function automatic t_btn next_btn(input t_btn cur, input logic pressed);
        t_btn res;
        if (pressed) begin
            res = (cur == BTN_IDLE) ? BTN_DOWN : cur;
        end else begin
            res = (cur == BTN_DOWN) ? BTN_UP : BTN_IDLE;
        end
        return res;
    endfunction

    // Screen size to highest cursor coordinate; zero acts as one.
    function automatic logic [POS_W-1:0] size_limit(input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] dec;
        logic [POS_W-1:0]  res;
        dec = size - SIZE_W'(1);
        if (size == '0) begin
            res = '0;
        end else if (size > SIZE_MAX) begin
            res = '1;
        end else begin
            res = dec[POS_W-1:0];
        end
        return res;
    endfunction

endpackage

[design/ps2mpt_byte_if.sv]
// Valid/ready channel that carries one raw mouse byte per transaction.
// Depends on ps2mpt_pkg.
interface ps2mpt_byte_if import ps2mpt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

[design/ps2mpt_pkt_if.sv]
// Valid/ready channel that carries one decoded packet result per transaction.
// Depends on ps2mpt_pkg.
interface ps2mpt_pkt_if import ps2mpt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] cursor_x;
    logic [POS_W-1:0] cursor_y;
    t_btn             left_state;
    t_btn             right_state;
    t_btn             middle_state;

    modport source (output valid, output cursor_x, output cursor_y, output left_state,
                    output right_state, output middle_state, input ready);
    modport sink   (input valid, input cursor_x, input cursor_y, input left_state,
                    input right_state, input middle_state, output ready);
endinterface

[design/ps2_mouse_packet_tracker.sv]
// Top level of the PS/2 mouse three-byte packet tracker.
// Depends on ps2mpt_pkg, ps2mpt_byte_if, ps2mpt_pkt_if and ps2mpt_axis.
//
//  channel  | dir | payload                                         | per transaction
//  ---------+-----+-------------------------------------------------+-------------------
//  i_byte   | in  | data_byte                                       | one mouse byte
//  o_pkt    | out | cursor_x, cursor_y, left/right/middle_state     | one full packet
//  i_cfg_*  | in  | screen size write (0 width, 1 height)           | write-only
//
// Cycles: one byte per cycle unless a final byte waits on a held result; a byte
// lands in the input register and is decoded from there, and a packet result is
// loaded into the output register when its third byte is decoded.
// Reset: synchronous, active low; the tracker waits for the 0xFA acknowledge,
// the cursor sits at 0,0 and all buttons are idle.
// Stalls: the output register holds a result until it is taken; a final
// packet byte waits in the input register only while that result is held.
module ps2_mouse_packet_tracker import ps2mpt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ps2mpt_byte_if.sink          i_byte,
    ps2mpt_pkt_if.source         o_pkt,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [SIZE_W-1:0]    i_cfg_data
);

    // Input register
    logic              r_in_vld;
    logic [BYTE_W-1:0] r_in_byte;

    // Packet decoder state
    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_hdr;
    logic [BYTE_W-1:0] r_xb;
    logic [POS_W-1:0]  r_pos_x, r_pos_y;
    t_btn              r_btn_l, r_btn_r, r_btn_m;

    // Clamp limits, precomputed from the written screen size at write time
    logic [POS_W-1:0]  r_lim_x, r_lim_y;

    // Output register
    logic              r_out_vld;

    logic                    out_free;
    logic                    is_last;
    logic                    s1_take;
    logic                    pkt_done;
    logic signed [DLT_W-1:0] dx, dy;
    logic [POS_W-1:0]        n_pos_x, n_pos_y;
    t_btn                    n_btn_l, n_btn_r, n_btn_m;

    // ------------------------------------------------------------------
    // Handshake: the decode stage drains the input register every cycle,
    // except a final packet byte while the previous result is still held.
    // ------------------------------------------------------------------
    assign out_free     = !r_out_vld || o_pkt.ready;
    assign is_last      = (r_phase == PH_YB);
    assign s1_take      = r_in_vld && (!is_last || out_free);
    assign pkt_done     = s1_take && is_last;
    assign i_byte.ready = !r_in_vld || s1_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_vld <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_in_byte <= i_byte.data_byte;
        end
    end

    // ------------------------------------------------------------------
    // Configuration: store size minus one, clamped to the cursor range.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim_x <= LIM_X_RST;
            r_lim_y <= LIM_Y_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WIDTH:  r_lim_x <= size_limit(i_cfg_data);
                CFG_HEIGHT: r_lim_y <= size_limit(i_cfg_data);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Packet phase: acknowledge, header sync, X byte, Y byte.
    // ------------------------------------------------------------------
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_ACK: if (r_in_byte == ACK_BYTE) n_phase = PH_HDR;
            PH_HDR: if ((r_in_byte & HDR_MASK) == HDR_MATCH) n_phase = PH_XB;
            PH_XB:  n_phase = PH_YB;
            PH_YB:  n_phase = PH_HDR;
            default: n_phase = PH_ACK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_ACK;
        end else if (s1_take) begin
            r_phase <= n_phase;
        end
    end

    // Capture header and X movement; no reset needed, always written first.
    always_ff @(posedge i_clk) begin
        if (s1_take && r_phase == PH_HDR && n_phase == PH_XB) begin
            r_hdr <= r_in_byte;
        end
        if (s1_take && r_phase == PH_XB) begin
            r_xb <= r_in_byte;
        end
    end

    // ------------------------------------------------------------------
    // Packet completion: sign-extend the movements from the header sign
    // bits, negate Y (mouse Y grows upward), move and clamp the cursor.
    // ------------------------------------------------------------------
    assign dx = $signed({r_hdr[HDR_XSIGN], r_hdr[HDR_XSIGN], r_xb});
    assign dy = -$signed({r_hdr[HDR_YSIGN], r_hdr[HDR_YSIGN], r_in_byte});

    ps2mpt_axis u_axis_x (
        .i_pos   (r_pos_x),
        .i_delta (dx),
        .i_limit (r_lim_x),
        .o_pos   (n_pos_x)
    );

    ps2mpt_axis u_axis_y (
        .i_pos   (r_pos_y),
        .i_delta (dy),
        .i_limit (r_lim_y),
        .o_pos   (n_pos_y)
    );

    // Press turns idle into down and keeps down or up; release turns down into up, else idle.
    assign n_btn_l = next_btn(r_btn_l, r_hdr[HDR_LEFT]);
    assign n_btn_r = next_btn(r_btn_r, r_hdr[HDR_RIGHT]);
    assign n_btn_m = next_btn(r_btn_m, r_hdr[HDR_MID]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_btn_l <= BTN_IDLE;
            r_btn_r <= BTN_IDLE;
            r_btn_m <= BTN_IDLE;
        end else if (pkt_done) begin
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
            r_btn_l <= n_btn_l;
            r_btn_r <= n_btn_r;
            r_btn_m <= n_btn_m;
        end
    end

    // ------------------------------------------------------------------
    // Output register: load on packet completion, drop when taken.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (pkt_done) begin
            r_out_vld <= 1'b1;
        end else if (o_pkt.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pkt_done) begin
            o_pkt.cursor_x     <= n_pos_x;
            o_pkt.cursor_y     <= n_pos_y;
            o_pkt.left_state   <= n_btn_l;
            o_pkt.right_state  <= n_btn_r;
            o_pkt.middle_state <= n_btn_m;
        end
    end

    assign o_pkt.valid = r_out_vld;

endmodule

[design/ps2mpt_axis.sv]
// One cursor axis: add a signed movement and clamp to 0..limit.
// Depends on ps2mpt_pkg.
module ps2mpt_axis import ps2mpt_pkg::*; (
    input  logic [POS_W-1:0]        i_pos,
    input  logic signed [DLT_W-1:0] i_delta,
    input  logic [POS_W-1:0]        i_limit,
    output logic [POS_W-1:0]        o_pos
);
    localparam int SUM_W = POS_W + 2;

    logic signed [SUM_W-1:0] sum;

    assign sum = $signed({2'b00, i_pos}) + $signed({{(SUM_W-DLT_W){i_delta[DLT_W-1]}}, i_delta});

    always_comb begin
        if (sum[SUM_W-1]) begin
            o_pos = '0;
        end else if (sum[SUM_W-2:0] > {1'b0, i_limit}) begin
            o_pos = i_limit;
        end else begin
            o_pos = sum[POS_W-1:0];
        end
    end
endmodule

[design/ps2mpt_checker.sv]
// Port-level checks of the PS/2 packet tracker, bound to the top level.
// Depends on ps2mpt_pkg and ps2_mouse_packet_tracker_defines.svh.
`include "ps2_mouse_packet_tracker_defines.svh"

module ps2mpt_checker import ps2mpt_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [POS_W-1:0] i_cursor_x,
    input logic [POS_W-1:0] i_cursor_y,
    input t_btn             i_left,
    input t_btn             i_right,
    input t_btn             i_middle
);

    // No result is offered right after reset.
    `PS2MPT_ASSERT_RST(a_rst_no_out, !i_rst_n |=> !i_out_valid, "result valid after reset")

    // A stalled result holds its payload.
    `PS2MPT_ASSERT(a_out_hold,
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_cursor_x)
            && $stable(i_cursor_y) && $stable(i_left) && $stable(i_right)
            && $stable(i_middle),
        "stalled result changed")

    // Button states use only the three defined codes.
    `PS2MPT_ASSERT(a_btn_codes,
        i_out_valid |-> (i_left == BTN_IDLE || i_left == BTN_DOWN || i_left == BTN_UP)
            && (i_right == BTN_IDLE || i_right == BTN_DOWN || i_right == BTN_UP)
            && (i_middle == BTN_IDLE || i_middle == BTN_DOWN || i_middle == BTN_UP),
        "bad button code")

    // With the output free, an offered byte is always taken.
    `PS2MPT_ASSERT(a_in_ready, !i_out_valid && i_in_valid |-> i_in_ready, "input stalled with free output")

endmodule

bind ps2_mouse_packet_tracker ps2mpt_checker u_ps2mpt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_byte.valid),
    .i_in_ready  (i_byte.ready),
    .i_out_valid (o_pkt.valid),
    .i_out_ready (o_pkt.ready),
    .i_cursor_x  (o_pkt.cursor_x),
    .i_cursor_y  (o_pkt.cursor_y),
    .i_left      (o_pkt.left_state),
    .i_right     (o_pkt.right_state),
    .i_middle    (o_pkt.middle_state)
);

[sim/ps2mpt_packet_checker.sv]
// Checker of the PS/2 mouse packet tracker: predicts each packet result and compares it.
// Depends on ps2mpt_pkg, ps2mpt_byte_if and ps2mpt_pkt_if; watches the channels and config writes only.
module ps2mpt_packet_checker import ps2mpt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ps2mpt_byte_if               byte_ch,
    ps2mpt_pkt_if                pkt_ch,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [SIZE_W-1:0]    i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct {
        logic [POS_W-1:0] cursor_x;
        logic [POS_W-1:0] cursor_y;
        t_btn             left_state;
        t_btn             right_state;
        t_btn             middle_state;
    } t_packet;

    t_packet           expected_packets[$];
    t_phase            phase;
    logic [BYTE_W-1:0] hdr_byte;
    logic [BYTE_W-1:0] x_byte;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    t_btn              left_btn;
    t_btn              right_btn;
    t_btn              middle_btn;
    logic [SIZE_W-1:0] screen_w;
    logic [SIZE_W-1:0] screen_h;
    int                fail_total;

    function automatic t_btn update_button(input t_btn cur, input logic pressed);
        if (pressed) begin
            return (cur == BTN_IDLE) ? BTN_DOWN : cur;
        end
        return (cur == BTN_DOWN) ? BTN_UP : BTN_IDLE;
    endfunction

    // Size zero behaves as one; sizes above the maximum behave as the maximum.
    function automatic logic [POS_W-1:0] move_cursor(input logic [POS_W-1:0] pos,
                                                     input int delta,
                                                     input logic [SIZE_W-1:0] size);
        int top;
        int v;
        if (size == '0) begin
            top = 0;
        end else if (size > SIZE_MAX) begin
            top = int'(SIZE_MAX) - 1;
        end else begin
            top = int'(size) - 1;
        end
        v = int'(pos) + delta;
        if (v < 0) v = 0;
        if (v > top) v = top;
        return POS_W'(v);
    endfunction

    task automatic take_byte(input logic [BYTE_W-1:0] b);
        t_packet pkt;
        int      dx;
        int      dy;
        case (phase)
            PH_ACK: begin
                if (b == ACK_BYTE) phase = PH_HDR;
            end
            PH_HDR: begin
                if ((b & HDR_MASK) == HDR_MATCH) begin
                    hdr_byte = b;
                    phase    = PH_XB;
                end
            end
            PH_XB: begin
                x_byte = b;
                phase  = PH_YB;
            end
            default: begin
                phase = PH_HDR;
                dx = int'($signed({hdr_byte[HDR_XSIGN], x_byte}));
                dy = -int'($signed({hdr_byte[HDR_YSIGN], b}));
                pos_x      = move_cursor(pos_x, dx, screen_w);
                pos_y      = move_cursor(pos_y, dy, screen_h);
                left_btn   = update_button(left_btn, hdr_byte[HDR_LEFT]);
                right_btn  = update_button(right_btn, hdr_byte[HDR_RIGHT]);
                middle_btn = update_button(middle_btn, hdr_byte[HDR_MID]);
                pkt.cursor_x     = pos_x;
                pkt.cursor_y     = pos_y;
                pkt.left_state   = left_btn;
                pkt.right_state  = right_btn;
                pkt.middle_state = middle_btn;
                expected_packets.push_back(pkt);
            end
        endcase
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        t_packet want;
        if (!i_rst_n) begin
            phase      = PH_ACK;
            hdr_byte   = '0;
            x_byte     = '0;
            pos_x      = '0;
            pos_y      = '0;
            left_btn   = BTN_IDLE;
            right_btn  = BTN_IDLE;
            middle_btn = BTN_IDLE;
            screen_w   = 13'd1024;
            screen_h   = 13'd768;
            fail_total = 0;
            expected_packets.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_WIDTH) screen_w = i_cfg_data;
                else if (i_cfg_idx == CFG_HEIGHT) screen_h = i_cfg_data;
            end
            if (pkt_ch.valid && pkt_ch.ready) begin
                if (expected_packets.size() == 0) begin
                    $display("%0t: packet mismatch: expected none, actual x=%0d y=%0d",
                             $time, pkt_ch.cursor_x, pkt_ch.cursor_y);
                    fail_total++;
                end else begin
                    want = expected_packets.pop_front();
                    compare_field("cursor_x", want.cursor_x, pkt_ch.cursor_x);
                    compare_field("cursor_y", want.cursor_y, pkt_ch.cursor_y);
                    compare_field("left_state", want.left_state, pkt_ch.left_state);
                    compare_field("right_state", want.right_state, pkt_ch.right_state);
                    compare_field("middle_state", want.middle_state, pkt_ch.middle_state);
                end
            end
            if (byte_ch.valid && byte_ch.ready) take_byte(byte_ch.data_byte);
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_packets.size();
    end

endmodule

[sim/tb_ps2_mouse_packet_tracker.sv]
// Testbench top of the PS/2 mouse packet tracker: clock, reset, stimulus and verdict.
// Depends on ps2mpt_pkg, both channel interfaces, the tracker and ps2mpt_packet_checker.
module tb_ps2_mouse_packet_tracker;
    import ps2mpt_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    // Cycles to hold after every expected packet has been taken.
    localparam int DRAIN_HOLD      = 8;
    localparam int NUM_PHASES      = 8;
    localparam int PACKETS_PER_PHASE = 66;
    localparam int NUM_DIRECTED    = 24;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [SIZE_W-1:0]    cfg_data;
    int                   fail_count;
    int                   pending_packets;
    int                   cycle_count = 0;
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;
    logic                 drift_x = 1'b0;
    logic                 drift_y = 1'b0;

    ps2mpt_byte_if byte_ch ();
    ps2mpt_pkt_if  pkt_ch ();

    ps2_mouse_packet_tracker dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte     (byte_ch),
        .o_pkt      (pkt_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    ps2mpt_packet_checker packet_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .byte_ch      (byte_ch),
        .pkt_ch       (pkt_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_packets)
    );

    // Directed opening: junk before the acknowledge (one byte looks like a header),
    // then headers with a bad pattern, then packets that hit the movement extremes,
    // the sign bits, the Y clamp at zero, and the button presses and releases, including a
    // press while in up that must keep up.
    localparam logic [BYTE_W-1:0] DIRECTED_BYTES [NUM_DIRECTED] = '{
        8'h08, 8'h00, 8'hFF, 8'hFB, 8'hFA,
        8'hC8, 8'h48, 8'h88, 8'hF7,
        8'h0F, 8'hFF, 8'h00,
        8'h08, 8'hFF, 8'hFF,
        8'h0F, 8'h00, 8'h80,
        8'h38, 8'h00, 8'h00,
        8'h38, 8'hFF, 8'hFF
    };

    // Screen sizes per random phase: minimum, maximum, zero and oversize values, a mixed
    // pair, one pair drawn at random (phase five, chosen below), 2 by 4096 and the reset size.
    localparam int PHASE_W [NUM_PHASES] = '{1, 4096, 0, 4097, 640, 8191, 2, 1024};
    localparam int PHASE_H [NUM_PHASES] = '{1, 4096, 8191, 0, 480, 1, 4096, 768};

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Receiver: stall at random per the current phase, or accept every cycle.
    always @(posedge i_clk) begin
        pkt_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: end the run if the traffic never drains.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Offer one byte, idling first at random, and return once it is accepted.
    // Valid stays high on return so back-to-back bytes need no gap.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
    endtask

    // Drop valid, wait until every expected packet has been taken, then hold.
    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_packets != 0);
        repeat (DRAIN_HOLD) @(posedge i_clk);
    endtask

    // Write both screen registers on consecutive edges; only while idle.
    task automatic write_screen(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_WIDTH;
        cfg_data <= w;
        @(posedge i_clk);
        cfg_idx  <= CFG_HEIGHT;
        cfg_data <= h;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // Mostly follow the current drift so the cursor reaches the far clamps too.
    function automatic logic pick_sign(input logic drift);
        return ($urandom_range(3) != 0) ? drift : 1'($urandom_range(1));
    endfunction

    task automatic send_packet();
        logic [BYTE_W-1:0] hdr;
        hdr = BYTE_W'($urandom);
        hdr = (hdr & ~HDR_MASK) | HDR_MATCH;
        hdr[HDR_XSIGN] = pick_sign(drift_x);
        hdr[HDR_YSIGN] = pick_sign(drift_y);
        send_byte(hdr);
        send_byte(BYTE_W'($urandom));
        send_byte(BYTE_W'($urandom));
    endtask

    initial begin
        int  packets;
        int  choice;
        bit  paused;
        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = CFG_WIDTH;
        cfg_data          = '0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = '0;
        pkt_ch.ready      = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part runs with the reset screen size.
        for (int i = 0; i < NUM_DIRECTED; i++) send_byte(DIRECTED_BYTES[i]);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            if (ph == 5) begin
                write_screen(SIZE_W'($urandom_range(1, 4096)), SIZE_W'($urandom_range(1, 4096)));
            end else begin
                write_screen(SIZE_W'(PHASE_W[ph]), SIZE_W'(PHASE_H[ph]));
            end
            // Cycle through: no idling, sender idle, receiver stall, both.
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            packets = 0;
            paused  = 1'b0;
            while (packets < PACKETS_PER_PHASE) begin
                // Once per phase, hold off until the tracker has drained.
                if (!paused && packets >= PACKETS_PER_PHASE / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
                if (packets % 20 == 0) begin
                    drift_x = 1'($urandom_range(1));
                    drift_y = 1'($urandom_range(1));
                end
                choice = $urandom_range(9);
                if (choice == 0) begin
                    // Noise: may be dropped, or may start or shift a packet.
                    send_byte(BYTE_W'($urandom));
                end else if (choice == 1) begin
                    send_byte(ACK_BYTE);
                end else begin
                    send_packet();
                    packets++;
                end
            end
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
